FILE: hdl/cccu_pkg.sv
// Shared widths, queue constants and status types for the cross-correlation unit.
package cccu_pkg;

	localparam int SAMP_W  = 16;
	localparam int PROD_W  = 32;
	localparam int CORR_W  = 32;
	localparam int LAG_W   = 6;
	localparam int Q_DEPTH = 2;
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

FILE: hdl/cccu_queue.sv
// Two-entry job queue between the loader and the correlation engine.
module cccu_queue #(
	parameter int W = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [W-1:0]     push_data,
	input  logic             pop,
	output logic [W-1:0]     head,
	output cccu_pkg::q_stat_t stat
);
	import cccu_pkg::*;

	logic [W-1:0]       entry_q [0:Q_DEPTH-1];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	// store the pushed job
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + Q_CNT_W'(1);
				2'b01:   count_q <= count_q - Q_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign head       = entry_q[rd_ptr_q];
	assign stat.full  = (count_q == Q_CNT_W'(Q_DEPTH));
	assign stat.empty = (count_q == '0);

endmodule

FILE: hdl/cccu_front.sv
// Loader: takes sample transfers, fills the free bank and queues finished windows.
module cccu_front #(
	parameter int MAX_LEN = 64,
	parameter int IDX_W   = $clog2(MAX_LEN),
	parameter int CNT_W   = $clog2(MAX_LEN + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [cccu_pkg::SAMP_W-1:0]  series_a,
	input  logic [cccu_pkg::SAMP_W-1:0]  series_b,
	input  logic                         last_sample,
	input  cccu_pkg::q_stat_t            q_stat,
	output logic                         busy,
	output logic                         wr_en,
	output logic [IDX_W:0]               wr_addr,
	output logic [cccu_pkg::SAMP_W-1:0]  wr_a,
	output logic [cccu_pkg::SAMP_W-1:0]  wr_b,
	output logic                         push,
	output logic [IDX_W:0]               push_data
);
	import cccu_pkg::*;

	logic             wbank_q;
	logic [CNT_W-1:0] cnt_q;
	logic             accept;
	logic             room;
	logic [IDX_W-1:0] n_m1;

	// both banks held by queued jobs: refuse transfers
	assign busy   = q_stat.full;
	assign accept = start && !q_stat.full;
	assign room   = (cnt_q < CNT_W'(MAX_LEN));

	// write the pair while the window has room
	assign wr_en   = accept && room;
	assign wr_addr = {wbank_q, cnt_q[IDX_W-1:0]};
	assign wr_a    = series_a;
	assign wr_b    = series_b;

	// window length minus one, capped at the store depth
	assign n_m1      = room ? cnt_q[IDX_W-1:0] : IDX_W'(MAX_LEN - 1);
	assign push      = accept && last_sample;
	assign push_data = {wbank_q, n_m1};

	// advance fill count, swap bank when a window closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wbank_q <= 1'b0;
			cnt_q   <= '0;
		end else if (accept) begin
			if (last_sample) begin
				cnt_q   <= '0;
				wbank_q <= ~wbank_q;
			end else if (room) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

endmodule

FILE: hdl/cccu_div.sv
// Sequential signed divider: lag sum over window length, truncated toward zero.
module cccu_div #(
	parameter int MAX_LEN = 64,
	parameter int IDX_W   = $clog2(MAX_LEN),
	parameter int CNT_W   = $clog2(MAX_LEN + 1),
	parameter int ACC_W   = 32 + IDX_W
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         go,
	input  logic signed [ACC_W-1:0]      sum,
	input  logic [CNT_W-1:0]             len,
	input  logic [IDX_W-1:0]             lag_in,
	input  logic                         last_in,
	output logic                         div_busy,
	output logic                         strobe,
	output logic [cccu_pkg::LAG_W-1:0]   lag,
	output logic [cccu_pkg::CORR_W-1:0]  correlation,
	output logic                         last_lag
);
	import cccu_pkg::*;

	localparam int MAG_W  = ACC_W - 1;
	localparam int STEP_W = $clog2(MAG_W + 1);

	logic [STEP_W-1:0] cnt_q;
	logic              neg_q;
	logic [MAG_W-1:0]  quo_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  den_q;
	logic [IDX_W-1:0]  lag_q;
	logic              lastl_q;
	logic              strobe_q;
	logic [CORR_W-1:0] corr_q;
	logic [LAG_W-1:0]  lag_out_q;
	logic              last_out_q;

	logic [MAG_W-1:0]  mag;
	logic [CNT_W:0]    shifted;
	logic [CNT_W:0]    diff;
	logic              ge;
	logic [CNT_W-1:0]  rem_nx;
	logic [MAG_W-1:0]  quo_nx;
	logic [MAG_W-1:0]  quo_sgn;
	logic              final_step;

	// magnitude of the dividend
	assign mag = sum[ACC_W-1] ? MAG_W'(-sum) : MAG_W'(sum);

	// one restoring step per cycle
	assign shifted    = {rem_q, quo_q[MAG_W-1]};
	assign diff       = shifted - {1'b0, den_q};
	assign ge         = (shifted >= {1'b0, den_q});
	assign rem_nx     = ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
	assign quo_nx     = {quo_q[MAG_W-2:0], ge};
	assign quo_sgn    = neg_q ? (~quo_nx + MAG_W'(1)) : quo_nx;
	assign final_step = (cnt_q == STEP_W'(1));

	// step counter and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (cnt_q != '0) && final_step;
			if (go) begin
				cnt_q <= STEP_W'(MAG_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - STEP_W'(1);
			end
		end
	end

	// load operands, iterate, hold the finished value
	always_ff @(posedge clk) begin
		if (go) begin
			neg_q   <= sum[ACC_W-1];
			quo_q   <= mag;
			rem_q   <= '0;
			den_q   <= len;
			lag_q   <= lag_in;
			lastl_q <= last_in;
		end else if (cnt_q != '0) begin
			quo_q <= quo_nx;
			rem_q <= rem_nx;
		end
		if ((cnt_q != '0) && final_step) begin
			corr_q     <= quo_sgn[CORR_W-1:0];
			lag_out_q  <= LAG_W'(lag_q);
			last_out_q <= lastl_q;
		end
	end

	assign div_busy    = (cnt_q != '0);
	assign strobe      = strobe_q;
	assign correlation = corr_q;
	assign lag         = lag_out_q;
	assign last_lag    = last_out_q;

endmodule

FILE: hdl/cccu_engine.sv
// Correlation engine: sample banks, lag sequencer and shared multiply-accumulate.
module cccu_engine #(
	parameter int MAX_LEN = 64,
	parameter int IDX_W   = $clog2(MAX_LEN),
	parameter int CNT_W   = $clog2(MAX_LEN + 1),
	parameter int ACC_W   = 32 + IDX_W
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [IDX_W:0]               wr_addr,
	input  logic [cccu_pkg::SAMP_W-1:0]  wr_a,
	input  logic [cccu_pkg::SAMP_W-1:0]  wr_b,
	input  cccu_pkg::q_stat_t            q_stat,
	input  logic [IDX_W:0]               head,
	output logic                         pop,
	input  logic                         div_busy,
	output logic                         go,
	output logic signed [ACC_W-1:0]      sum,
	output logic [CNT_W-1:0]             len,
	output logic [IDX_W-1:0]             lag_out,
	output logic                         last_out
);
	import cccu_pkg::*;

	localparam int DEPTH = 2 ** (IDX_W + 1);

	logic [SAMP_W-1:0] mem_a [0:DEPTH-1];
	logic [SAMP_W-1:0] mem_b [0:DEPTH-1];

	// sequencer
	logic             active_q;
	logic             bank_q;
	logic [IDX_W-1:0] nm1_q;
	logic [IDX_W-1:0] k_q;
	logic [IDX_W-1:0] t_q;
	logic [IDX_W-1:0] j_q;
	logic             inflight_q;
	logic [IDX_W-1:0] pend_lag_q;
	logic             pend_last_q;
	logic [CNT_W-1:0] pend_n_q;
	logic             issue;
	logic             t_end;
	logic             k_end;

	// pipeline
	logic                     valid_s1, first_s1, lastt_s1;
	logic signed [SAMP_W-1:0] a_s1, b_s1;
	logic                     valid_s2, first_s2, lastt_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     acc_done_q;

	// a new lag waits until the previous sum has gone to the divider
	assign issue = active_q && !((t_q == '0) && inflight_q);
	assign t_end = (t_q == nm1_q);
	assign k_end = (k_q == nm1_q);
	assign pop   = issue && t_end && k_end;
	assign go    = acc_done_q && !div_busy;

	// sample banks: one write port, one registered read each
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_a[wr_addr] <= wr_a;
			mem_b[wr_addr] <= wr_b;
		end
		a_s1 <= mem_a[{bank_q, t_q}];
		b_s1 <= mem_b[{bank_q, j_q}];
	end

	// walk lags and time steps of the current job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			bank_q      <= 1'b0;
			nm1_q       <= '0;
			k_q         <= '0;
			t_q         <= '0;
			j_q         <= '0;
			inflight_q  <= 1'b0;
			pend_lag_q  <= '0;
			pend_last_q <= 1'b0;
			pend_n_q    <= '0;
		end else begin
			if (!active_q) begin
				if (!q_stat.empty) begin
					active_q <= 1'b1;
					bank_q   <= head[IDX_W];
					nm1_q    <= head[IDX_W-1:0];
					k_q      <= '0;
					t_q      <= '0;
					j_q      <= '0;
				end
			end else if (issue) begin
				if (t_q == '0) begin
					pend_lag_q  <= k_q;
					pend_last_q <= k_end;
					pend_n_q    <= CNT_W'(nm1_q) + CNT_W'(1);
				end
				if (t_end) begin
					t_q <= '0;
					k_q <= k_q + IDX_W'(1);
					j_q <= k_q + IDX_W'(1);
					if (k_end) begin
						active_q <= 1'b0;
					end
				end else begin
					t_q <= t_q + IDX_W'(1);
					j_q <= (j_q == nm1_q) ? '0 : j_q + IDX_W'(1);
				end
			end
			// hold the credit from lag start until hand-off
			if (issue && (t_q == '0)) begin
				inflight_q <= 1'b1;
			end else if (go) begin
				inflight_q <= 1'b0;
			end
		end
	end

	// pipeline control bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			first_s1   <= 1'b0;
			lastt_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			first_s2   <= 1'b0;
			lastt_s2   <= 1'b0;
			acc_done_q <= 1'b0;
		end else begin
			valid_s1 <= issue;
			first_s1 <= (t_q == '0);
			lastt_s1 <= t_end;
			valid_s2 <= valid_s1;
			first_s2 <= first_s1;
			lastt_s2 <= lastt_s1;
			if (valid_s2 && lastt_s2) begin
				acc_done_q <= 1'b1;
			end else if (go) begin
				acc_done_q <= 1'b0;
			end
		end
	end

	// multiply, then accumulate
	always_ff @(posedge clk) begin
		prod_s2 <= a_s1 * b_s1;
		if (valid_s2) begin
			acc_q <= first_s2 ? ACC_W'(prod_s2) : acc_q + ACC_W'(prod_s2);
		end
	end

	assign sum      = acc_q;
	assign len      = pend_n_q;
	assign lag_out  = pend_lag_q;
	assign last_out = pend_last_q;

endmodule

FILE: hdl/circular_cross_correlation_unit.sv
// Top level of the circular cross-correlation unit.
//
// Input: one sample pair (series_a, series_b) transfers at each rising edge where
// start is high and busy is low. The pair with last_sample set closes the window
// of N pairs; pairs beyond MAX_LEN are dropped, so N is at most MAX_LEN.
// Output: N results, lag 0 to N-1 in order, each on lag/correlation/last_lag for
// exactly one cycle with strobe high; last_lag marks lag N-1. The receiver
// cannot stall: every strobe is a transfer.
// Two sample banks let a new window load while the previous one is processed;
// busy is high only while both banks hold windows awaiting or under processing.
// Each lag's products are summed on the shared multiply-accumulate, and its sum is
// then divided in the bit-serial divider, the two overlapping across lags. Reset
// empties both banks and the job queue; no clearing pass is needed, as only
// entries written in the current window are read.
module circular_cross_correlation_unit #(
	parameter int MAX_LEN = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [cccu_pkg::SAMP_W-1:0]  series_a,
	input  logic [cccu_pkg::SAMP_W-1:0]  series_b,
	input  logic                         last_sample,
	output logic                         strobe,
	output logic [cccu_pkg::LAG_W-1:0]   lag,
	output logic [cccu_pkg::CORR_W-1:0]  correlation,
	output logic                         last_lag
);
	import cccu_pkg::*;

	localparam int IDX_W = $clog2(MAX_LEN);
	localparam int CNT_W = $clog2(MAX_LEN + 1);
	localparam int ACC_W = 32 + IDX_W;

	q_stat_t                 q_stat;
	logic                    wr_en;
	logic [IDX_W:0]          wr_addr;
	logic [SAMP_W-1:0]       wr_a;
	logic [SAMP_W-1:0]       wr_b;
	logic                    push;
	logic [IDX_W:0]          push_data;
	logic                    pop;
	logic [IDX_W:0]          head;
	logic                    div_busy;
	logic                    go;
	logic signed [ACC_W-1:0] sum;
	logic [CNT_W-1:0]        len;
	logic [IDX_W-1:0]        lag_pend;
	logic                    last_pend;

	// accept pairs and close windows
	cccu_front #(.MAX_LEN(MAX_LEN), .IDX_W(IDX_W), .CNT_W(CNT_W)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.series_a    (series_a),
		.series_b    (series_b),
		.last_sample (last_sample),
		.q_stat      (q_stat),
		.busy        (busy),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_a        (wr_a),
		.wr_b        (wr_b),
		.push        (push),
		.push_data   (push_data)
	);

	// hold closed windows until the engine has read them
	cccu_queue #(.W(IDX_W + 1)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.stat      (q_stat)
	);

	// form the lag sums
	cccu_engine #(.MAX_LEN(MAX_LEN), .IDX_W(IDX_W), .CNT_W(CNT_W), .ACC_W(ACC_W)) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_a     (wr_a),
		.wr_b     (wr_b),
		.q_stat   (q_stat),
		.head     (head),
		.pop      (pop),
		.div_busy (div_busy),
		.go       (go),
		.sum      (sum),
		.len      (len),
		.lag_out  (lag_pend),
		.last_out (last_pend)
	);

	// scale each sum by the window length
	cccu_div #(.MAX_LEN(MAX_LEN), .IDX_W(IDX_W), .CNT_W(CNT_W), .ACC_W(ACC_W)) u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.go          (go),
		.sum         (sum),
		.len         (len),
		.lag_in      (lag_pend),
		.last_in     (last_pend),
		.div_busy    (div_busy),
		.strobe      (strobe),
		.lag         (lag),
		.correlation (correlation),
		.last_lag    (last_lag)
	);

endmodule

FILE: hdl/cccu_checker.sv
// Port-level checks for the cross-correlation unit, bound to the top level.
module cccu_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               start,
	input logic                               busy,
	input logic                               strobe,
	input logic [cccu_pkg::LAG_W-1:0]         lag,
	input logic signed [cccu_pkg::CORR_W-1:0] correlation,
	input logic                               last_lag
);
	import cccu_pkg::*;

	// reset clears the result strobe and frees the loader
	assert property (@(posedge clk) !arst_n |-> !strobe && !busy)
		else $error("strobe or busy during reset");

	// the divider takes one lag at a time: no two results back to back
	assert property (@(posedge clk) disable iff (!arst_n) strobe |=> !strobe)
		else $error("results on adjacent cycles");

	// busy rises only after a transfer fills the second bank
	assert property (@(posedge clk) disable iff (!arst_n) $rose(busy) |-> $past(start))
		else $error("busy rose without a transfer");

	// a mean of 16-bit products stays within the product range
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (correlation >= -32'sd1073741824) && (correlation <= 32'sd1073741824))
		else $error("correlation out of range");

	// the highest lag must close its run
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (lag == LAG_W'(63)) |-> last_lag)
		else $error("highest lag not marked last");

endmodule

bind circular_cross_correlation_unit cccu_checker u_checker (.*);
